// ===== hw/rtl/oaat_pkg.sv =====
// Shared types, constants and mixing functions for the one-at-a-time bucket index block.
package oaat_pkg;

  localparam int HASH_W = 32;
  localparam int BYTE_W = 8;

  localparam logic [HASH_W-1:0] BUCKET_COUNT_RESET = 32'h0001_0000;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } hash_xfer_t;

  // Fold one key byte into the running hash.
  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] t;
    t = h + {{(HASH_W-BYTE_W){1'b0}}, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  // Final avalanche after the last byte.
  function automatic logic [HASH_W-1:0] finalize(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

// ===== hw/rtl/one_at_a_time_hash_bucket_index_top.sv =====
// Top level of the one-at-a-time hash bucket index block.
//
// Keys arrive one byte per input transaction, the final byte flagged by
// in_last_byte. The front end folds each byte into a 32-bit running hash in
// the cycle it is accepted, so bytes of a key stream in at one per cycle
// while in_stall is low. On the final byte it finalises the hash and pushes
// it into a short queue (QUEUE_DEPTH entries), clearing the running hash for
// the next key. The back end pops one hash at a time and reduces it modulo
// bucket_count with a restoring divider that retires one quotient bit per
// cycle: for each key it loads the operands, runs 32 shift-subtract steps and
// loads the output register, waiting there while out_stall holds a result.
// When bucket_count is 0, which stands for 2^32, it skips the steps and passes
// the finalised hash straight through. That divider sets the sustained rate
// for short keys; the front end keeps taking bytes until the queue fills and
// a finished key cannot be pushed. One result transaction follows every key.
// bucket_count resets to 65536; write it only while the block is idle.

module one_at_a_time_hash_bucket_index_top
  import oaat_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_key_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HASH_W-1:0] out_bucket_index,
  input  logic              cfg_wr_en,
  input  logic [HASH_W-1:0] cfg_wr_data
);

  logic [HASH_W-1:0] bucket_count_r, bucket_count_nxt;
  hash_xfer_t        push;
  logic              push_ready;
  hash_xfer_t        pop;
  logic              pop_take;

  // Take the new divisor on a write; the back end latches it per key.
  assign bucket_count_nxt = cfg_wr_en ? cfg_wr_data : bucket_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RESET;
    end else begin
      bucket_count_r <= bucket_count_nxt;
    end
  end

  // Byte mixing and finalisation.
  oaat_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .push_ready   (push_ready)
  );

  // Decouple the byte stream from the slow reduction.
  oaat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_take   (pop_take)
  );

  // Modulo reduction and result register.
  oaat_mod u_mod (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop              (pop),
    .pop_take         (pop_take),
    .divisor          (bucket_count_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bucket_index (out_bucket_index)
  );

endmodule

// ===== hw/rtl/oaat_front.sv =====
// Front end: accepts key bytes, mixes them and pushes finalised hashes to the queue.
module oaat_front
  import oaat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_key_byte,
  input  logic              in_last_byte,
  output hash_xfer_t        push,
  input  logic              push_ready
);

  logic [HASH_W-1:0] run_hash_r, run_hash_nxt;
  logic [HASH_W-1:0] fin_hash_r, fin_hash_nxt;
  logic              fin_pend_r, fin_pend_nxt;
  logic [HASH_W-1:0] mixed;
  logic              accept;
  logic              push_done;

  assign mixed     = mix_byte(run_hash_r, in_key_byte);
  assign push_done = fin_pend_r && push_ready;
  // Hold the input only while a finished key waits for queue space.
  assign in_stall  = fin_pend_r && !push_ready;
  assign accept    = in_valid && !in_stall;

  assign push.valid = fin_pend_r;
  assign push.hash  = finalize(fin_hash_r);

  always_comb begin
    run_hash_nxt = run_hash_r;
    fin_hash_nxt = fin_hash_r;
    fin_pend_nxt = fin_pend_r;
    if (push_done) begin
      fin_pend_nxt = 1'b0;
    end
    if (accept) begin
      if (in_last_byte) begin
        run_hash_nxt = '0;
        fin_hash_nxt = mixed;
        fin_pend_nxt = 1'b1;
      end else begin
        run_hash_nxt = mixed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_hash_r <= '0;
      fin_pend_r <= 1'b0;
    end else begin
      run_hash_r <= run_hash_nxt;
      fin_pend_r <= fin_pend_nxt;
    end
    fin_hash_r <= fin_hash_nxt;
  end

endmodule

// ===== hw/rtl/oaat_queue.sv =====
// Short FIFO of finalised hashes between the front end and the modulo unit.
module oaat_queue
  import oaat_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  hash_xfer_t push,
  output logic       push_ready,
  output hash_xfer_t pop,
  input  logic       pop_take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [HASH_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop.valid  = (count_r != '0);
  assign pop.hash   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_take && pop.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.hash;
    end
  end

endmodule

// ===== hw/rtl/oaat_mod.sv =====
// Back end: bit-serial modulo reduction of each hash and the output register.
module oaat_mod
  import oaat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  hash_xfer_t        pop,
  output logic              pop_take,
  input  logic [HASH_W-1:0] divisor,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HASH_W-1:0] out_bucket_index
);

  localparam int STEP_W = $clog2(HASH_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [HASH_W-1:0] dvd_r, dvd_nxt;
  logic [HASH_W-1:0] div_r, div_nxt;
  logic [HASH_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] out_data_r, out_data_nxt;
  logic [HASH_W:0]   rem_shift;
  logic [HASH_W:0]   rem_sub;
  logic              out_free;

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  assign rem_shift = {rem_r, dvd_r[HASH_W-1]};
  assign rem_sub   = rem_shift - {1'b0, div_r};
  assign out_free  = !out_valid_r || !out_stall;

  assign pop_take         = (state_r == S_IDLE) && pop.valid;
  assign out_valid        = out_valid_r;
  assign out_bucket_index = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    dvd_nxt       = dvd_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (pop.valid) begin
          dvd_nxt  = pop.hash;
          div_nxt  = divisor;
          step_nxt = STEP_W'(HASH_W - 1);
          if (divisor == '0) begin
            rem_nxt   = pop.hash;
            state_nxt = S_HOLD;
          end else begin
            rem_nxt   = '0;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        rem_nxt  = rem_sub[HASH_W] ? rem_shift[HASH_W-1:0] : rem_sub[HASH_W-1:0];
        dvd_nxt  = {dvd_r[HASH_W-2:0], 1'b0};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_data_nxt  = rem_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dvd_r      <= dvd_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
